// ===== hw/rtl/qspe_pkg.sv =====
// package for the queued shortest path engine
// shared widths, op codes and defaults; no dependencies
package qspe_pkg;

  localparam int OpW      = 2;
  localparam int NodeW    = 11;
  localparam int WeightW  = 16;
  localparam int DistW    = 31;

  localparam int MaxNodesDef = 1024;
  localparam int MaxEdgesDef = 4096;

  localparam logic [OpW-1:0] OP_ADD     = 2'd0;
  localparam logic [OpW-1:0] OP_COMPUTE = 2'd1;
  localparam logic [OpW-1:0] OP_CLEAR   = 2'd2;

  localparam logic [DistW-1:0] DIST_INF   = 31'h7fffffff;
  localparam logic [NodeW-1:0] NODE_COUNT_RST = 11'd1;

endpackage

// ===== hw/rtl/qspe_in_if.sv =====
// input channel: one op word per handshake
// depends on qspe_pkg
interface qspe_in_if import qspe_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OpW-1:0]     op;
  logic [NodeW-1:0]   from_node;
  logic [NodeW-1:0]   to_node;
  logic [WeightW-1:0] weight;

  modport source (output valid, op, from_node, to_node, weight, input ready);
  modport sink   (input valid, op, from_node, to_node, weight, output ready);
endinterface

// ===== hw/rtl/qspe_out_if.sv =====
// output channel: one distance word per compute
// depends on qspe_pkg
interface qspe_out_if import qspe_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [DistW-1:0] distance;
  logic             edges_dropped;

  modport source (output valid, distance, edges_dropped, input ready);
  modport sink   (input valid, distance, edges_dropped, output ready);
endinterface

// ===== hw/rtl/qspe_edge_store.sv =====
// edge store: per-node list heads and the edge arrays
// single port memories with registered read; depends on qspe_pkg
module qspe_edge_store import qspe_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int MAX_EDGES = MaxEdgesDef,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int EW  = $clog2(MAX_EDGES + 1),
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  logic               clk_i,
  input  logic               head_we_i,
  input  logic [NW-1:0]      head_addr_i,
  input  logic [EW-1:0]      head_wdata_i,
  output logic [EW-1:0]      head_rdata_o,
  input  logic               edge_we_i,
  input  logic [EIW-1:0]     edge_addr_i,
  input  logic [EW-1:0]      link_wdata_i,
  input  logic [NW-1:0]      target_wdata_i,
  input  logic [WeightW-1:0] length_wdata_i,
  output logic [EW-1:0]      link_rdata_o,
  output logic [NW-1:0]      target_rdata_o,
  output logic [WeightW-1:0] length_rdata_o
);

  logic [EW-1:0]      head_mem   [MAX_NODES];
  logic [EW-1:0]      link_mem   [MAX_EDGES];
  logic [NW-1:0]      target_mem [MAX_EDGES];
  logic [WeightW-1:0] length_mem [MAX_EDGES];

  always_ff @(posedge clk_i) begin
    if (head_we_i) begin
      head_mem[head_addr_i] <= head_wdata_i;
    end
    head_rdata_o <= head_mem[head_addr_i];
  end

  always_ff @(posedge clk_i) begin
    if (edge_we_i) begin
      link_mem[edge_addr_i]   <= link_wdata_i;
      target_mem[edge_addr_i] <= target_wdata_i;
      length_mem[edge_addr_i] <= length_wdata_i;
    end
    link_rdata_o   <= link_mem[edge_addr_i];
    target_rdata_o <= target_mem[edge_addr_i];
    length_rdata_o <= length_mem[edge_addr_i];
  end

endmodule

// ===== hw/rtl/qspe_work_fifo.sv =====
// work queue of node indexes, circular buffer in one memory
// registered pop data; depends on qspe_pkg
module qspe_work_fifo import qspe_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDef,
  localparam int NW  = $clog2(MAX_NODES),
  localparam int NCW = $clog2(MAX_NODES + 1)
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           clear_i,
  input  logic           push_i,
  input  logic [NW-1:0]  push_data_i,
  input  logic           pop_i,
  output logic [NW-1:0]  pop_data_o,
  output logic [NCW-1:0] count_o
);

  logic [NW-1:0]  mem [MAX_NODES];
  logic [NW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [NCW-1:0] count_q;

  function automatic logic [NW-1:0] ptr_inc(input logic [NW-1:0] p);
    return (p == NW'(MAX_NODES - 1)) ? '0 : p + NW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else if (clear_i) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + NCW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - NCW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wr_ptr_q] <= push_data_i;
    end
    if (pop_i) begin
      pop_data_o <= mem[rd_ptr_q];
    end
  end

  assign count_o = count_q;

endmodule

// ===== hw/rtl/queued_shortest_path_engine_unit.sv =====
// queued shortest path engine top: sequencer, node tables, one shared relax unit
// depends on qspe_pkg, qspe_in_if, qspe_out_if, qspe_edge_store, qspe_work_fifo
//
// channel   dir  word                                    handshake
// in_i      in   op, from_node, to_node, weight          valid/ready
// out_o     out  distance, edges_dropped                 valid/ready
// cfg       in   cfg_wdata_i (node_count)                cfg_we_i, no wait
//
// add edge: head read, head and edge write; clear: head sweep; op 3, bad edges ignored
// compute: table init sweep, then per dequeued node a pop, head load and edge check
// plus target read, relax per edge, final target read; one adder/compare does it all
// after reset the list heads are swept with in_i.ready low
// a finished distance waits in the output register; only the next result stalls on it
module queued_shortest_path_engine_unit import qspe_pkg::*; #(
  parameter int MAX_NODES = MaxNodesDef,
  parameter int MAX_EDGES = MaxEdgesDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  qspe_in_if.sink          in_i,
  qspe_out_if.source       out_o,
  input  logic             cfg_we_i,
  input  logic [NodeW-1:0] cfg_wdata_i
);

  localparam int NW  = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int EW  = $clog2(MAX_EDGES + 1);
  localparam int EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam logic [EW-1:0] EMPTY = EW'(MAX_EDGES);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_INIT, ST_POP, ST_UHEAD,
    ST_ULOAD, ST_EDGE, ST_VREAD, ST_RELAX, ST_FIN_RD, ST_FIN_OUT
  } state_e;

  state_e           state_q;
  logic [NW-1:0]    sweep_q;
  logic [NodeW-1:0] node_count_q;
  logic [EW-1:0]    total_q;
  logic             overflow_q;
  logic [NW-1:0]    src_q, dst_q, tgt_q, v_q;
  logic [WeightW-1:0] w_q;
  logic [EW-1:0]    e_q;
  logic [DistW-1:0] du_q;
  logic             out_valid_q, out_dropped_q;
  logic [DistW-1:0] out_dist_q;

  // node tables
  logic [DistW-1:0] dist_mem [MAX_NODES];
  logic             mark_mem [MAX_NODES];
  logic [DistW-1:0] dist_rdata_q;
  logic             mark_rdata_q;
  logic             dist_we, mark_we, mark_wdata;
  logic [DistW-1:0] dist_wdata;
  logic [NW-1:0]    dist_addr, mark_addr;

  // store and queue hookup
  logic             head_we, edge_we;
  logic [NW-1:0]    head_addr;
  logic [EW-1:0]    head_wdata, head_rdata, link_rdata;
  logic [EIW-1:0]   edge_addr;
  logic [NW-1:0]    target_rdata;
  logic [WeightW-1:0] length_rdata;
  logic             fifo_clear, fifo_push, fifo_pop;
  logic [NW-1:0]    fifo_push_data, fifo_rdata;
  logic [NCW-1:0]   fifo_count;

  logic             in_fire, edge_bad, store_full, sweep_last, relax_hit;
  logic [31:0]      sum_raw;
  logic [DistW-1:0] sum_sat;

  assign in_fire    = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == ST_IDLE);
  assign edge_bad   = (in_i.from_node == '0) || (32'(in_i.from_node) > 32'(MAX_NODES)) ||
                      (in_i.to_node == '0) || (32'(in_i.to_node) > 32'(MAX_NODES));
  assign store_full = 32'(total_q) >= 32'(MAX_EDGES);
  assign sweep_last = (sweep_q == NW'(MAX_NODES - 1));

  // shared relax unit: saturating add, then compare against the stored distance
  assign sum_raw   = {1'b0, du_q} + 32'(length_rdata);
  assign sum_sat   = (du_q == DIST_INF || sum_raw[31]) ? DIST_INF : sum_raw[DistW-1:0];
  assign relax_hit = dist_rdata_q > sum_sat;

  always_comb begin
    head_we        = 1'b0;
    head_addr      = src_q;
    head_wdata     = total_q;
    edge_we        = 1'b0;
    edge_addr      = total_q[EIW-1:0];
    dist_we        = 1'b0;
    dist_addr      = v_q;
    dist_wdata     = sum_sat;
    mark_we        = 1'b0;
    mark_addr      = v_q;
    mark_wdata     = 1'b1;
    fifo_clear     = 1'b0;
    fifo_push      = 1'b0;
    fifo_push_data = v_q;
    fifo_pop       = 1'b0;
    case (state_q)
      ST_CLEAR: begin
        head_we    = 1'b1;
        head_addr  = sweep_q;
        head_wdata = EMPTY;
      end
      ST_ADD_WR: begin
        head_we = 1'b1;
        edge_we = 1'b1;
      end
      ST_INIT: begin
        dist_we    = 1'b1;
        dist_addr  = sweep_q;
        dist_wdata = (sweep_q == '0) ? '0 : DIST_INF;
        mark_we    = 1'b1;
        mark_addr  = sweep_q;
        mark_wdata = (sweep_q == '0);
        fifo_clear = (sweep_q == '0);
        // node 1 enters the queue on the last init cycle
        fifo_push      = sweep_last;
        fifo_push_data = '0;
      end
      ST_POP: begin
        fifo_pop = (fifo_count != '0);
      end
      ST_UHEAD: begin
        head_addr  = fifo_rdata;
        dist_addr  = fifo_rdata;
        mark_we    = 1'b1;
        mark_addr  = fifo_rdata;
        mark_wdata = 1'b0;
      end
      ST_EDGE: begin
        edge_addr = e_q[EIW-1:0];
      end
      ST_VREAD: begin
        edge_addr = e_q[EIW-1:0];
        dist_addr = target_rdata;
        mark_addr = target_rdata;
      end
      ST_RELAX: begin
        edge_addr = e_q[EIW-1:0];
        dist_we   = relax_hit;
        if (relax_hit && !mark_rdata_q && 32'(fifo_count) < 32'(MAX_NODES)) begin
          mark_we   = 1'b1;
          fifo_push = 1'b1;
        end
      end
      // keep the target read alive while the output register is busy
      ST_FIN_RD, ST_FIN_OUT: begin
        dist_addr = tgt_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (dist_we) begin
      dist_mem[dist_addr] <= dist_wdata;
    end
    dist_rdata_q <= dist_mem[dist_addr];
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      mark_mem[mark_addr] <= mark_wdata;
    end
    mark_rdata_q <= mark_mem[mark_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      sweep_q      <= '0;
      node_count_q <= NODE_COUNT_RST;
      total_q      <= '0;
      overflow_q   <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        node_count_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_CLEAR: begin
          sweep_q <= sweep_last ? '0 : sweep_q + NW'(1);
          if (sweep_last) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_fire) begin
            src_q <= NW'(in_i.from_node - NodeW'(1));
            dst_q <= NW'(in_i.to_node - NodeW'(1));
            w_q   <= in_i.weight;
            if (node_count_q == '0) begin
              tgt_q <= '0;
            end else if (32'(node_count_q) > 32'(MAX_NODES)) begin
              tgt_q <= NW'(MAX_NODES - 1);
            end else begin
              tgt_q <= NW'(node_count_q - NodeW'(1));
            end
            case (in_i.op)
              OP_ADD: begin
                if (!edge_bad) begin
                  if (store_full) begin
                    overflow_q <= 1'b1;
                  end else begin
                    state_q <= ST_ADD_RD;
                  end
                end
              end
              OP_COMPUTE: begin
                sweep_q <= '0;
                state_q <= ST_INIT;
              end
              OP_CLEAR: begin
                total_q    <= '0;
                overflow_q <= 1'b0;
                sweep_q    <= '0;
                state_q    <= ST_CLEAR;
              end
              default: begin
              end
            endcase
          end
        end
        ST_ADD_RD: begin
          state_q <= ST_ADD_WR;
        end
        ST_ADD_WR: begin
          total_q <= total_q + EW'(1);
          state_q <= ST_IDLE;
        end
        ST_INIT: begin
          sweep_q <= sweep_last ? '0 : sweep_q + NW'(1);
          if (sweep_last) begin
            state_q <= ST_POP;
          end
        end
        ST_POP: begin
          state_q <= (fifo_count != '0) ? ST_UHEAD : ST_FIN_RD;
        end
        ST_UHEAD: begin
          state_q <= ST_ULOAD;
        end
        ST_ULOAD: begin
          e_q     <= head_rdata;
          du_q    <= dist_rdata_q;
          state_q <= ST_EDGE;
        end
        ST_EDGE: begin
          state_q <= (e_q < total_q) ? ST_VREAD : ST_POP;
        end
        ST_VREAD: begin
          v_q     <= target_rdata;
          state_q <= ST_RELAX;
        end
        ST_RELAX: begin
          e_q     <= link_rdata;
          state_q <= ST_EDGE;
        end
        ST_FIN_RD: begin
          state_q <= ST_FIN_OUT;
        end
        ST_FIN_OUT: begin
          if (!out_valid_q || out_o.ready) begin
            out_valid_q   <= 1'b1;
            out_dist_q    <= dist_rdata_q;
            out_dropped_q <= overflow_q;
            state_q       <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.distance      = out_dist_q;
  assign out_o.edges_dropped = out_dropped_q;

  qspe_edge_store #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_store (
    .clk_i          (clk_i),
    .head_we_i      (head_we),
    .head_addr_i    (head_addr),
    .head_wdata_i   (head_wdata),
    .head_rdata_o   (head_rdata),
    .edge_we_i      (edge_we),
    .edge_addr_i    (edge_addr),
    .link_wdata_i   (head_rdata),
    .target_wdata_i (dst_q),
    .length_wdata_i (w_q),
    .link_rdata_o   (link_rdata),
    .target_rdata_o (target_rdata),
    .length_rdata_o (length_rdata)
  );

  qspe_work_fifo #(
    .MAX_NODES (MAX_NODES)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (fifo_clear),
    .push_i      (fifo_push),
    .push_data_i (fifo_push_data),
    .pop_i       (fifo_pop),
    .pop_data_o  (fifo_rdata),
    .count_o     (fifo_count)
  );

  // a compute word keeps the block busy on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_i.op == OP_COMPUTE |=> !in_i.ready)
    else $error("compute did not start");

  // the work queue never holds more than MAX_NODES entries
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fifo_count) <= 32'(MAX_NODES))
    else $error("work queue over capacity");

  // relaxation only ever works on a stored edge
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_RELAX |-> e_q < total_q)
    else $error("relax on an edge past the store");

  // a new result never overwrites one still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_o.ready |=> out_valid_q)
    else $error("pending result lost");

endmodule

// ===== dv/queued_shortest_path_engine_unit_tb.sv =====
// testbench for the queued shortest path engine: directed and random op words
// checked against an in-bench shortest path predictor
// depends on qspe_pkg, qspe_in_if, qspe_out_if and the engine top
module queued_shortest_path_engine_unit_tb;
  import qspe_pkg::*;

  localparam int NNODES = MaxNodesDef;
  localparam int NEDGES = MaxEdgesDef;
  localparam int SETTLE = NNODES + 100;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             dropped;
  } path_word_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [NodeW-1:0] cfg_wdata_i = '0;

  qspe_in_if  in_ch ();
  qspe_out_if out_ch ();

  queued_shortest_path_engine_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (in_ch),
    .out_o      (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // graph mirror
  int unsigned head_of[NNODES];
  int unsigned next_edge[NEDGES];
  int unsigned edge_dst[NEDGES];
  int unsigned edge_len[NEDGES];
  int unsigned edge_cnt;
  bit          store_overflow;
  int unsigned target_reg;

  path_word_t pending_paths[$];
  int unsigned mismatches = 0;
  int unsigned paths_checked = 0;
  int unsigned words_sent = 0;
  int unsigned edges_loaded = 0;
  bit quiet = 1'b0;

  function automatic void wipe_graph();
    for (int i = 0; i < NNODES; i++) head_of[i] = NEDGES;
    edge_cnt = 0;
    store_overflow = 1'b0;
  endfunction

  function automatic logic [DistW-1:0] shortest_dist();
    int unsigned best[NNODES];
    bit          marked[NNODES];
    int unsigned work[$];
    int unsigned tgt, u, e, v, sum;
    tgt = target_reg;
    if (tgt == 0) tgt = 1;
    if (tgt > NNODES) tgt = NNODES;
    for (int i = 0; i < NNODES; i++) begin
      best[i] = 32'(DIST_INF);
      marked[i] = 1'b0;
    end
    best[0] = 0;
    marked[0] = 1'b1;
    work.push_back(0);
    while (work.size() > 0) begin
      u = work.pop_front();
      marked[u] = 1'b0;
      e = head_of[u];
      while (e < edge_cnt) begin
        v = edge_dst[e];
        sum = best[u] + edge_len[e];
        if (best[u] >= DIST_INF || sum > DIST_INF) sum = 32'(DIST_INF);
        if (best[v] > sum) begin
          best[v] = sum;
          if (!marked[v]) begin
            marked[v] = 1'b1;
            work.push_back(v);
          end
        end
        e = next_edge[e];
      end
    end
    return best[tgt-1][DistW-1:0];
  endfunction

  function automatic void apply_word(logic [OpW-1:0] op, logic [NodeW-1:0] src,
                                     logic [NodeW-1:0] dst, logic [WeightW-1:0] w);
    path_word_t pw;
    if (op == OP_ADD) begin
      if (src == 0 || src > NNODES || dst == 0 || dst > NNODES) return;
      if (edge_cnt >= NEDGES) begin
        store_overflow = 1'b1;
        return;
      end
      next_edge[edge_cnt] = head_of[src-1];
      edge_dst[edge_cnt] = 32'(dst) - 1;
      edge_len[edge_cnt] = 32'(w);
      head_of[src-1] = edge_cnt;
      edge_cnt++;
      edges_loaded++;
    end else if (op == OP_COMPUTE) begin
      pw.distance = shortest_dist();
      pw.dropped = store_overflow;
      pending_paths.push_back(pw);
    end else if (op == OP_CLEAR) begin
      wipe_graph();
    end
  endfunction

  task automatic send_word(logic [OpW-1:0] op, logic [NodeW-1:0] src,
                           logic [NodeW-1:0] dst, logic [WeightW-1:0] w);
    int unsigned gap;
    in_ch.valid <= 1'b1;
    in_ch.op <= op;
    in_ch.from_node <= src;
    in_ch.to_node <= dst;
    in_ch.weight <= w;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_word(op, src, dst, w);
    words_sent++;
    gap = quiet ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic add_edge(int src, int dst, int w);
    send_word(OP_ADD, src[NodeW-1:0], dst[NodeW-1:0], w[WeightW-1:0]);
  endtask

  task automatic compute_path();
    send_word(OP_COMPUTE, NodeW'($urandom), NodeW'($urandom), WeightW'($urandom));
  endtask

  task automatic clear_graph();
    send_word(OP_CLEAR, NodeW'($urandom), NodeW'($urandom), WeightW'($urandom));
  endtask

  // wait for the last word out plus a full clear sweep before touching the register
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (pending_paths.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_target(int unsigned n);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[NodeW-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    target_reg = n & 11'h7ff;
  endtask

  // sink side: random stall after each word
  initial begin
    int unsigned gap;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      out_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!(out_ch.valid && out_ch.ready));
      gap = quiet ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    path_word_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_paths.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: distance %0d dropped %0d",
                   out_ch.distance, out_ch.edges_dropped);
      end else begin
        want = pending_paths.pop_front();
        paths_checked++;
        if (out_ch.distance !== want.distance || out_ch.edges_dropped !== want.dropped) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: distance exp %0d got %0d, dropped exp %0d got %0d",
                     want.distance, out_ch.distance, want.dropped, out_ch.edges_dropped);
        end
      end
    end
  end

  task automatic test_empty_graph();
    set_target(1);
    compute_path();
    set_target(0);
    compute_path();
  endtask

  task automatic test_small_paths();
    set_target(3);
    add_edge(1, 2, 5);
    add_edge(2, 3, 7);
    add_edge(1, 3, 20);
    add_edge(1, 3, 16'hffff);
    add_edge(3, 3, 0);
    add_edge(2, 1, 0);
    compute_path();
    // ignored words: bad node indexes and the unused op
    add_edge(0, 3, 1);
    add_edge(1, 0, 1);
    add_edge(1025, 2047, 1);
    add_edge(1, 2047, 0);
    send_word(2'd3, 11'd1, 11'd3, 16'd0);
    compute_path();
    set_target(2047);
    compute_path();
    add_edge(1, 1024, 16'hffff);
    add_edge(1024, 1024, 0);
    compute_path();
    set_target(1024);
    compute_path();
    clear_graph();
    compute_path();
  endtask

  task automatic test_store_full();
    quiet = 1'b1;
    clear_graph();
    add_edge(1, 2, 9);
    // unreachable self loops fill the store without slowing the search
    for (int i = 1; i < NEDGES; i++) add_edge(1024, 1024, $urandom);
    add_edge(3, 4, 1);
    quiet = 1'b0;
    set_target(2);
    compute_path();
    compute_path();
    clear_graph();
    compute_path();
  endtask

  task automatic test_random_graphs();
    int unsigned span, n_edges, budget, phases, pick;
    budget = 0;
    phases = 0;
    while (budget < 1450) begin
      quiet = ($urandom_range(0, 3) == 0);
      span = $urandom_range(2, 14);
      pick = $urandom_range(0, 9);
      if (pick == 0) set_target(0);
      else if (pick == 1) set_target(1024);
      else if (pick == 2) set_target($urandom_range(1025, 2047));
      else if (phases == 0 || pick > 4) set_target($urandom_range(1, span));
      if (phases % 3 == 0 || $urandom_range(0, 1)) begin
        clear_graph();
        budget++;
      end
      n_edges = $urandom_range(0, 3 * span);
      for (int i = 0; i < n_edges; i++) begin
        pick = $urandom_range(0, 19);
        if (pick == 0) begin
          send_word(OpW'($urandom), NodeW'($urandom), NodeW'($urandom),
                    WeightW'($urandom));
        end else if (pick == 1) begin
          add_edge($urandom_range(1, span), 1024, $urandom_range(0, 100));
        end else if (pick == 2) begin
          add_edge(1024, $urandom_range(1, span), $urandom);
        end else begin
          add_edge($urandom_range(1, span), $urandom_range(1, span),
                   $urandom_range(0, 1) ? $urandom : $urandom_range(0, 50));
          budget++;
        end
        if ($urandom_range(0, 15) == 0) begin
          compute_path();
          budget++;
        end
      end
      compute_path();
      budget++;
      phases++;
    end
    quiet = 1'b0;
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.op = OP_ADD;
    in_ch.from_node = '0;
    in_ch.to_node = '0;
    in_ch.weight = '0;
    target_reg = 32'(NODE_COUNT_RST);
    wipe_graph();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_empty_graph();
    test_small_paths();
    test_store_full();
    test_random_graphs();
    drain();
    mismatches += pending_paths.size();
    $display("sent %0d words, loaded %0d edges, checked %0d path results",
             words_sent, edges_loaded, paths_checked);
    $display("covered ignored words, store overflow, target extremes and random graphs");
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("simulation failed");
    $finish;
  end

endmodule

// ===== queued_shortest_path_engine_unit.f =====
hw/rtl/qspe_pkg.sv
hw/rtl/qspe_in_if.sv
hw/rtl/qspe_out_if.sv
hw/rtl/qspe_edge_store.sv
hw/rtl/qspe_work_fifo.sv
hw/rtl/queued_shortest_path_engine_unit.sv
dv/queued_shortest_path_engine_unit_tb.sv
